FILE: hw/rtl/qs_pkg.sv
// Shared constants, types and functions of the quaternion interpolator.
`default_nettype none
package qs_pkg;

   localparam int QS_FRAC       = 15;
   localparam int QS_WBITS      = 30;
   localparam int QS_TRIG_STEPS = 16;
   localparam int QS_CW         = 34;
   localparam int QS_SPH_ROOT_W = 31;
   localparam int QS_LIN_ROOT_W = 25;
   localparam int QS_SPH_NW     = 62;
   localparam int QS_SPH_DW     = 33;
   localparam int QS_SPH_QW     = 33;
   localparam int QS_LIN_NW     = 42;
   localparam int QS_LIN_QW     = 17;

   localparam logic [15:0] QS_THR_RESET = 16'd32440;
   localparam logic [15:0] QS_BLEND_ONE = 16'd32768;

   typedef logic signed [15:0] comp_type;
   typedef logic signed [16:0] bcomp_type;
   typedef logic signed [17:0] lr_type;

   typedef struct packed {
      logic [15:0]          t;
      comp_type [3:0]       a;
      bcomp_type [3:0]      bn;
      logic                 lin;
   } side_type;

   function automatic logic signed [QS_CW-1:0] atan_at(input int unsigned i);
      logic signed [QS_CW-1:0] unit;
      unit = 34'sd1;
      case (i)
         0:  atan_at = 34'sd843314857;
         1:  atan_at = 34'sd497837829;
         2:  atan_at = 34'sd263043837;
         3:  atan_at = 34'sd133525159;
         4:  atan_at = 34'sd67021687;
         5:  atan_at = 34'sd33543516;
         6:  atan_at = 34'sd16775851;
         7:  atan_at = 34'sd8388437;
         8:  atan_at = 34'sd4194283;
         9:  atan_at = 34'sd2097149;
         10: atan_at = 34'sd1048576;
         default: atan_at = (i <= QS_WBITS) ? (unit << (QS_WBITS - i)) : '0;
      endcase
   endfunction

   function automatic comp_type sat16(input logic signed [31:0] v);
      if (v > 32'sd32767) begin
         sat16 = 16'sh7fff;
      end else if (v < -32'sd32768) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[15:0];
      end
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/quaternion_slerp.sv
// Quaternion spherical interpolation with normalized linear fallback, fully pipelined.
// Throughput: one request per cycle; busy is high only during reset.
// Latency is set by the 31-cell root, two TRIG_STEPS CORDIC rows and the 33-cell divider.
// Reset is synchronous: it clears the in-flight valid line and loads the threshold 32440.
`default_nettype none
module quaternion_slerp #(
   parameter int TRIG_STEPS = qs_pkg::QS_TRIG_STEPS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [15:0]             req_blend,
   input  logic signed [15:0]      req_a_x,
   input  logic signed [15:0]      req_a_y,
   input  logic signed [15:0]      req_a_z,
   input  logic signed [15:0]      req_a_w,
   input  logic signed [15:0]      req_b_x,
   input  logic signed [15:0]      req_b_y,
   input  logic signed [15:0]      req_b_z,
   input  logic signed [15:0]      req_b_w,
   output logic                    rsp_strobe,
   output logic signed [15:0]      rsp_out_x,
   output logic signed [15:0]      rsp_out_y,
   output logic signed [15:0]      rsp_out_z,
   output logic signed [15:0]      rsp_out_w,
   output logic                    rsp_used_linear,
   input  logic                    csr_wr_en,
   input  logic [15:0]             csr_wr_data
);

   localparam int CW    = qs_pkg::QS_CW;
   localparam int SRW   = qs_pkg::QS_SPH_ROOT_W;
   localparam int LRW   = qs_pkg::QS_LIN_ROOT_W;
   localparam int SNW   = qs_pkg::QS_SPH_NW;
   localparam int SDW   = qs_pkg::QS_SPH_DW;
   localparam int SQW   = qs_pkg::QS_SPH_QW;
   localparam int LNW   = qs_pkg::QS_LIN_NW;
   localparam int LQW   = qs_pkg::QS_LIN_QW;

   localparam int S_SQ  = 4;
   localparam int S_Y0  = S_SQ + SRW;
   localparam int S_TH  = S_Y0 + TRIG_STEPS;
   localparam int S_PT  = S_TH + 1;
   localparam int S_PHI = S_PT + 1;
   localparam int S_SIN = S_PHI + TRIG_STEPS;
   localparam int S_DP  = S_SIN + 1;
   localparam int S_Q   = S_DP + SQW;
   localparam int S_W   = S_Q + 1;
   localparam int S_PR  = S_W + 1;
   localparam int LAT   = S_PR + 1;
   localparam int S_L6  = 6;
   localparam int S_LEN = S_L6 + LRW;
   localparam int S_LDP = S_LEN + 1;
   localparam int S_LQ  = S_LDP + LQW;
   localparam int S_LO  = S_LQ + 1;

   // control
   logic [LAT-1:0] valid_ff;
   logic [15:0]    thr_ff;

   assign busy       = reset;
   assign rsp_strobe = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         thr_ff   <= qs_pkg::QS_THR_RESET;
      end else begin
         valid_ff <= {valid_ff[LAT-2:0], start & ~busy};
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   // stage 1: capture request, component products
   qs_pkg::comp_type a_req [4];
   qs_pkg::comp_type b_req [4];
   assign a_req[0] = req_a_x;
   assign a_req[1] = req_a_y;
   assign a_req[2] = req_a_z;
   assign a_req[3] = req_a_w;
   assign b_req[0] = req_b_x;
   assign b_req[1] = req_b_y;
   assign b_req[2] = req_b_z;
   assign b_req[3] = req_b_w;

   logic [15:0]         t1_ff;
   qs_pkg::comp_type    a1_ff [4];
   qs_pkg::comp_type    b1_ff [4];
   logic signed [31:0]  p1_ff [4];

   always_ff @(posedge clock) begin
      t1_ff <= (req_blend > qs_pkg::QS_BLEND_ONE) ? qs_pkg::QS_BLEND_ONE : req_blend;
      for (int i = 0; i < 4; i++) begin
         a1_ff[i] <= a_req[i];
         b1_ff[i] <= b_req[i];
         p1_ff[i] <= a_req[i] * b_req[i];
      end
   end

   // stage 2: dot product, shortest path, path choice
   logic signed [33:0]  dot_w;
   logic                neg_w;
   logic [32:0]         mag_w;
   qs_pkg::bcomp_type   bn_w [4];

   logic [15:0]         t2_ff;
   qs_pkg::comp_type    a2_ff [4];
   qs_pkg::bcomp_type   bn2_ff [4];
   logic signed [17:0]  diff2_ff [4];
   logic [30:0]         d2_ff;
   logic                lin2_ff;

   always_comb begin
      dot_w = '0;
      for (int i = 0; i < 4; i++) begin
         dot_w = dot_w + 34'(p1_ff[i]);
      end
      neg_w = dot_w[33];
      mag_w = neg_w ? 33'(-dot_w) : 33'(dot_w);
      for (int i = 0; i < 4; i++) begin
         bn_w[i] = neg_w ? -17'(b1_ff[i]) : 17'(b1_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      t2_ff   <= t1_ff;
      lin2_ff <= mag_w >= {2'b00, thr_ff, 15'd0};
      d2_ff   <= (mag_w > 33'h0_4000_0000) ? 31'h4000_0000 : mag_w[30:0];
      for (int i = 0; i < 4; i++) begin
         a2_ff[i]    <= a1_ff[i];
         bn2_ff[i]   <= bn_w[i];
         diff2_ff[i] <= 18'(bn_w[i]) - 18'(a1_ff[i]);
      end
   end

   qs_pkg::side_type side2_w, side_th, side_q;
   always_comb begin
      side2_w.t   = t2_ff;
      side2_w.lin = lin2_ff;
      for (int i = 0; i < 4; i++) begin
         side2_w.a[i]  = a2_ff[i];
         side2_w.bn[i] = bn2_ff[i];
      end
   end

   // spherical: sqrt(1 - d^2)
   logic [61:0] dsq3_ff, v4_ff;
   logic [30:0] d3_ff, d4_ff, d_y0;

   always_ff @(posedge clock) begin
      dsq3_ff <= d2_ff * d2_ff;
      d3_ff   <= d2_ff;
      v4_ff   <= (62'd1 << 60) - dsq3_ff;
      d4_ff   <= d3_ff;
   end

   logic [SRW:0]     srem  [SRW+1];
   logic [SRW-1:0]   sroot [SRW+1];
   logic [2*SRW-1:0] sv    [SRW+1];
   assign srem[0]  = '0;
   assign sroot[0] = '0;
   assign sv[0]    = v4_ff;

   for (genvar k = 0; k < SRW; k++) begin : g_sroot
      qs_sqrt_cell #(.N(SRW)) u_cell (
         .clock (clock),
         .rem_i (srem[k]),  .root_i (sroot[k]),  .v_i (sv[k]),
         .rem_o (srem[k+1]), .root_o (sroot[k+1]), .v_o (sv[k+1])
      );
   end

   qs_delay #(.WIDTH(31), .DEPTH(SRW)) u_d_dly (.clock(clock), .d(d4_ff), .q(d_y0));

   // spherical: angle by vectoring
   logic signed [CW-1:0] vx [TRIG_STEPS+1];
   logic signed [CW-1:0] vy [TRIG_STEPS+1];
   logic signed [CW-1:0] vz [TRIG_STEPS+1];
   assign vx[0] = $signed({3'b000, d_y0});
   assign vy[0] = $signed({3'b000, sroot[SRW]});
   assign vz[0] = '0;

   for (genvar k = 0; k < TRIG_STEPS; k++) begin : g_vec
      qs_cordic_cell #(.VECTOR(1'b1), .STEP(k)) u_cell (
         .clock (clock),
         .x_i (vx[k]), .y_i (vy[k]), .z_i (vz[k]),
         .x_o (vx[k+1]), .y_o (vy[k+1]), .z_o (vz[k+1])
      );
   end

   qs_delay #(.WIDTH($bits(qs_pkg::side_type)), .DEPTH(S_TH - 2)) u_side_th (
      .clock(clock), .d(side2_w), .q(side_th)
   );

   // spherical: split angle
   logic signed [50:0]   pt_ff;
   logic signed [CW-1:0] theta_pt_ff, phi2_w;
   logic signed [CW-1:0] phi_ff [3];

   always_ff @(posedge clock) begin
      pt_ff       <= $signed({1'b0, side_th.t}) * vz[TRIG_STEPS];
      theta_pt_ff <= vz[TRIG_STEPS];
   end

   assign phi2_w = CW'((pt_ff + 51'sd16384) >>> qs_pkg::QS_FRAC);

   always_ff @(posedge clock) begin
      phi_ff[0] <= theta_pt_ff - phi2_w;
      phi_ff[1] <= phi2_w;
      phi_ff[2] <= theta_pt_ff;
   end

   // spherical: three sines
   logic signed [CW-1:0] rx [3][TRIG_STEPS+1];
   logic signed [CW-1:0] ry [3][TRIG_STEPS+1];
   logic signed [CW-1:0] rz [3][TRIG_STEPS+1];

   for (genvar l = 0; l < 3; l++) begin : g_sin
      assign rx[l][0] = CW'(64'd1 << qs_pkg::QS_WBITS);
      assign ry[l][0] = '0;
      assign rz[l][0] = phi_ff[l];
      for (genvar k = 0; k < TRIG_STEPS; k++) begin : g_step
         qs_cordic_cell #(.VECTOR(1'b0), .STEP(k)) u_cell (
            .clock (clock),
            .x_i (rx[l][k]), .y_i (ry[l][k]), .z_i (rz[l][k]),
            .x_o (rx[l][k+1]), .y_o (ry[l][k+1]), .z_o (rz[l][k+1])
         );
      end
   end

   // spherical: weight division setup
   logic signed [CW-1:0] sth_w;
   logic [31:0]          smag_w [2];
   logic [SNW-1:0]       snum_w [2];
   logic [SNW-1:0]       dnum_ff [2];
   logic [SDW-1:0]       dden_ff;
   logic [1:0]           sneg_ff, sovf_ff;
   logic                 fb_ff;

   assign sth_w = ry[2][TRIG_STEPS];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         smag_w[l] = ry[l][TRIG_STEPS][CW-1] ? 32'(-ry[l][TRIG_STEPS])
                                             : 32'(ry[l][TRIG_STEPS]);
         snum_w[l] = SNW'(smag_w[l]) << qs_pkg::QS_WBITS;
      end
   end

   always_ff @(posedge clock) begin
      dden_ff <= sth_w[SDW-1:0];
      fb_ff   <= sth_w[CW-1] || (sth_w == '0);
      for (int l = 0; l < 2; l++) begin
         dnum_ff[l] <= snum_w[l];
         sneg_ff[l] <= ry[l][TRIG_STEPS][CW-1];
         sovf_ff[l] <= (66'(snum_w[l]) >= {sth_w[SDW-1:0], 33'd0});
      end
   end

   logic [SNW-1:0] drem [2][SQW+1];
   logic [SDW-1:0] dden [2][SQW+1];
   logic [SQW-1:0] dq   [2][SQW+1];

   for (genvar l = 0; l < 2; l++) begin : g_sdiv
      assign drem[l][0] = dnum_ff[l];
      assign dden[l][0] = dden_ff;
      assign dq[l][0]   = '0;
      for (genvar k = 0; k < SQW; k++) begin : g_bit
         qs_div_cell #(.NW(SNW), .DW(SDW), .QW(SQW), .BIT(SQW - 1 - k)) u_cell (
            .clock (clock),
            .rem_i (drem[l][k]), .den_i (dden[l][k]), .q_i (dq[l][k]),
            .rem_o (drem[l][k+1]), .den_o (dden[l][k+1]), .q_o (dq[l][k+1])
         );
      end
   end

   logic [4:0] sflag_q;
   qs_delay #(.WIDTH(5), .DEPTH(SQW)) u_sflag (
      .clock(clock), .d({fb_ff, sneg_ff, sovf_ff}), .q(sflag_q)
   );

   qs_delay #(.WIDTH($bits(qs_pkg::side_type)), .DEPTH(S_Q - S_TH)) u_side_q (
      .clock(clock), .d(side_th), .q(side_q)
   );

   // spherical: weights, products, blend
   logic signed [32:0]  w_ff [2];
   logic signed [32:0]  t30_w;
   logic [SQW-1:0]      wmag_w [2];
   qs_pkg::comp_type    aw_ff [4];
   qs_pkg::bcomp_type   bw_ff [4];
   logic                linw_ff, linp_ff;
   logic signed [50:0]  pa_ff [4];
   logic signed [50:0]  pb_ff [4];

   assign t30_w = $signed({2'b00, side_q.t, 15'd0});

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         wmag_w[l] = (sflag_q[l] || dq[l][SQW] > 33'h0_8000_0000) ? 33'h0_8000_0000
                                                                 : dq[l][SQW];
      end
   end

   always_ff @(posedge clock) begin
      if (sflag_q[4]) begin
         w_ff[0] <= 33'sh0_4000_0000 - t30_w;
         w_ff[1] <= t30_w;
      end else begin
         w_ff[0] <= sflag_q[2] ? -$signed(wmag_w[0]) : $signed(wmag_w[0]);
         w_ff[1] <= sflag_q[3] ? -$signed(wmag_w[1]) : $signed(wmag_w[1]);
      end
      linw_ff <= side_q.lin;
      for (int i = 0; i < 4; i++) begin
         aw_ff[i] <= side_q.a[i];
         bw_ff[i] <= side_q.bn[i];
      end
   end

   always_ff @(posedge clock) begin
      linp_ff <= linw_ff;
      for (int i = 0; i < 4; i++) begin
         pa_ff[i] <= w_ff[0] * aw_ff[i];
         pb_ff[i] <= w_ff[1] * bw_ff[i];
      end
   end

   // linear: blend, length
   logic signed [34:0]  lp3_ff [4];
   qs_pkg::comp_type    la3_ff [4];
   qs_pkg::lr_type      r4_ff [4];
   logic [35:0]         sq5_ff [4];
   qs_pkg::lr_type [3:0] r5_ff, r6_ff, r_len;
   logic [2*LRW-1:0]    sum6_ff;
   logic [37:0]         sum_w;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         lp3_ff[i] <= diff2_ff[i] * $signed({1'b0, t2_ff});
         la3_ff[i] <= a2_ff[i];
         r4_ff[i]  <= 18'(la3_ff[i]) + 18'((lp3_ff[i] + 35'sd16384) >>> qs_pkg::QS_FRAC);
         sq5_ff[i] <= 36'(r4_ff[i] * r4_ff[i]);
         r5_ff[i]  <= r4_ff[i];
      end
   end

   always_comb begin
      sum_w = '0;
      for (int i = 0; i < 4; i++) begin
         sum_w = sum_w + 38'(sq5_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      sum6_ff <= (2*LRW)'(sum_w) << 16;
      r6_ff   <= r5_ff;
   end

   logic [LRW:0]     lrem  [LRW+1];
   logic [LRW-1:0]   lroot [LRW+1];
   logic [2*LRW-1:0] lv    [LRW+1];
   assign lrem[0]  = '0;
   assign lroot[0] = '0;
   assign lv[0]    = sum6_ff;

   for (genvar k = 0; k < LRW; k++) begin : g_lroot
      qs_sqrt_cell #(.N(LRW)) u_cell (
         .clock (clock),
         .rem_i (lrem[k]),  .root_i (lroot[k]),  .v_i (lv[k]),
         .rem_o (lrem[k+1]), .root_o (lroot[k+1]), .v_o (lv[k+1])
      );
   end

   qs_delay #(.WIDTH($bits(r6_ff)), .DEPTH(LRW)) u_r_dly (.clock(clock), .d(r6_ff), .q(r_len));

   // linear: normalize
   logic [LRW-1:0] len_w;
   logic [40:0]    un_w [4];
   logic [LNW-1:0] lnum_w [4];
   logic [LNW-1:0] lnum_ff [4];
   logic [LRW-1:0] lden_ff;
   logic [3:0]     lneg_ff, lovf_ff;
   logic           lzero_ff;

   assign len_w = lroot[LRW];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         un_w[i]   = (r_len[i][17] ? 41'(-r_len[i]) : 41'(r_len[i])) << 23;
         lnum_w[i] = LNW'(un_w[i]) + LNW'(len_w >> 1);
      end
   end

   always_ff @(posedge clock) begin
      lden_ff  <= len_w;
      lzero_ff <= len_w == '0;
      for (int i = 0; i < 4; i++) begin
         lnum_ff[i] <= lnum_w[i];
         lneg_ff[i] <= r_len[i][17];
         lovf_ff[i] <= 43'(lnum_w[i]) >= {1'b0, len_w, 17'd0};
      end
   end

   logic [LNW-1:0] lrm  [4][LQW+1];
   logic [LRW-1:0] ldn  [4][LQW+1];
   logic [LQW-1:0] lq   [4][LQW+1];

   for (genvar l = 0; l < 4; l++) begin : g_ldiv
      assign lrm[l][0] = lnum_ff[l];
      assign ldn[l][0] = lden_ff;
      assign lq[l][0]  = '0;
      for (genvar k = 0; k < LQW; k++) begin : g_bit
         qs_div_cell #(.NW(LNW), .DW(LRW), .QW(LQW), .BIT(LQW - 1 - k)) u_cell (
            .clock (clock),
            .rem_i (lrm[l][k]), .den_i (ldn[l][k]), .q_i (lq[l][k]),
            .rem_o (lrm[l][k+1]), .den_o (ldn[l][k+1]), .q_o (lq[l][k+1])
         );
      end
   end

   logic [8:0] lflag_q;
   qs_delay #(.WIDTH(9), .DEPTH(LQW)) u_lflag (
      .clock(clock), .d({lzero_ff, lneg_ff, lovf_ff}), .q(lflag_q)
   );

   qs_pkg::comp_type [3:0] lo_ff, lo_dly;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (lflag_q[8]) begin
            lo_ff[i] <= '0;
         end else if (lflag_q[4+i]) begin
            lo_ff[i] <= (lflag_q[i] || lq[i][LQW] > 17'd32768) ? 16'sh8000
                                                               : 16'(-lq[i][LQW]);
         end else begin
            lo_ff[i] <= (lflag_q[i] || lq[i][LQW] > 17'd32767) ? 16'sh7fff
                                                               : 16'(lq[i][LQW]);
         end
      end
   end

   qs_delay #(.WIDTH($bits(lo_ff)), .DEPTH(LAT - 1 - S_LO)) u_lo_dly (
      .clock(clock), .d(lo_ff), .q(lo_dly)
   );

   // output select
   qs_pkg::comp_type    out_ff [4];
   logic                used_ff;
   logic signed [50:0]  bl_w [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         bl_w[i] = (pa_ff[i] + pb_ff[i] + 51'sh2000_0000) >>> qs_pkg::QS_WBITS;
      end
   end

   always_ff @(posedge clock) begin
      used_ff <= linp_ff;
      for (int i = 0; i < 4; i++) begin
         out_ff[i] <= linp_ff ? lo_dly[i] : qs_pkg::sat16(32'(bl_w[i]));
      end
   end

   assign rsp_out_x       = out_ff[0];
   assign rsp_out_y       = out_ff[1];
   assign rsp_out_z       = out_ff[2];
   assign rsp_out_w       = out_ff[3];
   assign rsp_used_linear = used_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(start && !busy, LAT))
      else $error("response strobe out of step with accepted requests");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff[S_Y0-1] |->
         (64'(sroot[SRW]) * 64'(sroot[SRW]) + 64'(d_y0) * 64'(d_y0) <= (64'd1 << 60)) &&
         ((64'(sroot[SRW]) + 64'd1) * (64'(sroot[SRW]) + 64'd1) + 64'(d_y0) * 64'(d_y0)
            > (64'd1 << 60)))
      else $error("root row lost alignment with the dot magnitude");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/qs_delay.sv
// Fixed-length register delay line.
`default_nettype none
module qs_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [DEPTH-1:0][WIDTH-1:0] line_ff;

   always_ff @(posedge clock) begin
      line_ff[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
         line_ff[i] <= line_ff[i-1];
      end
   end

   assign q = line_ff[DEPTH-1];

endmodule
`default_nettype wire

FILE: hw/rtl/qs_sqrt_cell.sv
// One result bit of a pipelined integer square root.
`default_nettype none
module qs_sqrt_cell #(
   parameter int N = 8
) (
   input  logic           clock,
   input  logic [N:0]     rem_i,
   input  logic [N-1:0]   root_i,
   input  logic [2*N-1:0] v_i,
   output logic [N:0]     rem_o,
   output logic [N-1:0]   root_o,
   output logic [2*N-1:0] v_o
);

   logic [N:0]     rem_ff, rem_in;
   logic [N-1:0]   root_ff, root_in;
   logic [2*N-1:0] v_ff, v_in;
   logic [N+2:0]   trial_w, test_w, diff_w;
   logic           ge_w;

   always_comb begin
      trial_w = {rem_i, v_i[2*N-1 -: 2]};
      test_w  = {1'b0, root_i, 2'b01};
      ge_w    = trial_w >= test_w;
      diff_w  = trial_w - test_w;
      rem_in  = ge_w ? diff_w[N:0] : trial_w[N:0];
      root_in = {root_i[N-2:0], ge_w};
      v_in    = {v_i[2*N-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      v_ff    <= v_in;
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign v_o    = v_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/qs_cordic_cell.sv
// One CORDIC micro-rotation, vectoring or rotation mode.
`default_nettype none
module qs_cordic_cell #(
   parameter bit VECTOR = 1'b0,
   parameter int STEP   = 0
) (
   input  logic                              clock,
   input  logic signed [qs_pkg::QS_CW-1:0]   x_i,
   input  logic signed [qs_pkg::QS_CW-1:0]   y_i,
   input  logic signed [qs_pkg::QS_CW-1:0]   z_i,
   output logic signed [qs_pkg::QS_CW-1:0]   x_o,
   output logic signed [qs_pkg::QS_CW-1:0]   y_o,
   output logic signed [qs_pkg::QS_CW-1:0]   z_o
);

   localparam logic signed [qs_pkg::QS_CW-1:0] ATAN = qs_pkg::atan_at(STEP);

   logic signed [qs_pkg::QS_CW-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;

   always_comb begin
      x_in = x_i;
      y_in = y_i;
      z_in = z_i;
      if (VECTOR) begin
         if (y_i != '0) begin
            if (!y_i[qs_pkg::QS_CW-1]) begin
               x_in = x_i + (y_i >>> STEP);
               y_in = y_i - (x_i >>> STEP);
               z_in = z_i + ATAN;
            end else begin
               x_in = x_i - (y_i >>> STEP);
               y_in = y_i + (x_i >>> STEP);
               z_in = z_i - ATAN;
            end
         end
      end else begin
         if (!z_i[qs_pkg::QS_CW-1]) begin
            x_in = x_i - (y_i >>> STEP);
            y_in = y_i + (x_i >>> STEP);
            z_in = z_i - ATAN;
         end else begin
            x_in = x_i + (y_i >>> STEP);
            y_in = y_i - (x_i >>> STEP);
            z_in = z_i + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/qs_div_cell.sv
// One quotient bit of a pipelined restoring divider.
`default_nettype none
module qs_div_cell #(
   parameter int NW  = 8,
   parameter int DW  = 8,
   parameter int QW  = 8,
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic [NW-1:0] rem_i,
   input  logic [DW-1:0] den_i,
   input  logic [QW-1:0] q_i,
   output logic [NW-1:0] rem_o,
   output logic [DW-1:0] den_o,
   output logic [QW-1:0] q_o
);

   localparam int CW = NW + DW + QW;

   logic [NW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff;
   logic [QW-1:0] q_ff, q_in;
   logic [CW-1:0] rem_x, sub_x, dif_x;
   logic          ge_w;

   always_comb begin
      rem_x  = CW'(rem_i);
      sub_x  = CW'(den_i) << BIT;
      dif_x  = rem_x - sub_x;
      ge_w   = rem_x >= sub_x;
      rem_in = ge_w ? dif_x[NW-1:0] : rem_i;
      q_in   = q_i | (QW'(ge_w) << BIT);
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_i;
      q_ff   <= q_in;
   end

   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign q_o   = q_ff;

endmodule
`default_nettype wire

FILE: verif/quaternion_slerp_tb.sv
// Self-checking testbench for the quaternion slerp block with an in-bench fixed-point predictor.
module quaternion_slerp_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef qs_pkg::comp_type comp_type;

   typedef struct {
      logic [15:0] blend;
      comp_type    a[4];
      comp_type    b[4];
   } request_type;

   typedef struct {
      comp_type o[4];
      logic     lin;
   } quat_result_type;

   typedef struct {
      request_type     req;
      logic            typed;
      quat_result_type res;
   } stim_row_type;

   localparam longint ATAN_HEAD[11] = '{843314857, 497837829, 263043837, 133525159,
      67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [15:0] req_blend = '0;
   comp_type req_a[4] = '{default: '0};
   comp_type req_b[4] = '{default: '0};
   logic rsp_strobe;
   comp_type rsp_out[4];
   logic rsp_used_linear;
   logic csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   logic [15:0] threshold = qs_pkg::QS_THR_RESET;
   quat_result_type expected_q[$];
   logic cur_typed = 1'b0;
   quat_result_type cur_res;
   stim_row_type rows[$];
   int idle_pct = 8;
   int n_errors = 0;
   int n_checked = 0;
   int n_linear = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400000;
      $display("Timeout at %0t", $time);
      $display("Mismatches found");
      $finish;
   end

   quaternion_slerp dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_blend(req_blend),
      .req_a_x(req_a[0]), .req_a_y(req_a[1]), .req_a_z(req_a[2]), .req_a_w(req_a[3]),
      .req_b_x(req_b[0]), .req_b_y(req_b[1]), .req_b_z(req_b[2]), .req_b_w(req_b[3]),
      .rsp_strobe(rsp_strobe),
      .rsp_out_x(rsp_out[0]), .rsp_out_y(rsp_out[1]), .rsp_out_z(rsp_out[2]),
      .rsp_out_w(rsp_out[3]), .rsp_used_linear(rsp_used_linear),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   function automatic longint arctan_step(int i);
      if (i < 11) return ATAN_HEAD[i];
      if (i <= 30) return longint'(1) << (30 - i);
      return 0;
   endfunction

   function automatic longint round_shift(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic comp_type clip16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return comp_type'(v);
   endfunction

   function automatic longint gain_sine(longint phi);
      longint x, y, z, nx, ny;
      x = longint'(1) << 30;
      y = 0;
      z = phi;
      for (int i = 0; i < qs_pkg::QS_TRIG_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= arctan_step(i);
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += arctan_step(i);
         end
         x = nx;
         y = ny;
      end
      return y;
   endfunction

   function automatic longint vector_angle(longint x, longint y);
      longint z, nx, ny;
      z = 0;
      for (int i = 0; i < qs_pkg::QS_TRIG_STEPS; i++) begin
         if (y != 0) begin
            if (y > 0) begin
               nx = x + (y >>> i); ny = y - (x >>> i); z += arctan_step(i);
            end else begin
               nx = x - (y >>> i); ny = y + (x >>> i); z -= arctan_step(i);
            end
            x = nx;
            y = ny;
         end
      end
      return z;
   endfunction

   function automatic longint sine_ratio(longint s, longint sth);
      longint lim, w;
      lim = longint'(1) << 31;
      w = (s * (longint'(1) << 30)) / sth;
      if (w > lim) w = lim;
      if (w < -lim) w = -lim;
      return w;
   endfunction

   function automatic quat_result_type slerp_predict(request_type q, logic [15:0] thr);
      quat_result_type res;
      longint t, dot, mag, d, y0, theta, t30, phi1, phi2, sth, w1, w2, n, qv;
      longint a[4], b[4], r[4];
      longint unsigned sum, len, un;
      t = q.blend;
      if (t > 32768) t = 32768;
      dot = 0;
      for (int i = 0; i < 4; i++) begin
         a[i] = q.a[i];
         b[i] = q.b[i];
         dot += a[i] * b[i];
      end
      mag = dot;
      if (dot < 0) begin
         mag = -dot;
         for (int i = 0; i < 4; i++) b[i] = -b[i];
      end
      res.lin = (mag >= longint'(thr) * 32768);
      if (res.lin) begin
         sum = 0;
         for (int i = 0; i < 4; i++) begin
            r[i] = a[i] + round_shift((b[i] - a[i]) * t, 15);
            sum += longint'(r[i] * r[i]);
         end
         len = root64(sum << 16);
         for (int i = 0; i < 4; i++) begin
            if (len == 0) begin
               res.o[i] = '0;
            end else begin
               n = r[i] * (longint'(1) << 23);
               un = (n < 0) ? -n : n;
               qv = longint'((un + len / 2) / len);
               res.o[i] = clip16(n < 0 ? -qv : qv);
            end
         end
      end else begin
         d = mag;
         if (d > (longint'(1) << 30)) d = longint'(1) << 30;
         y0 = longint'(root64((64'd1 << 60) - longint'(d * d)));
         theta = vector_angle(d, y0);
         t30 = t << 15;
         phi2 = round_shift(t30 * theta, 30);
         phi1 = theta - phi2;
         sth = gain_sine(theta);
         if (sth > 0) begin
            w1 = sine_ratio(gain_sine(phi1), sth);
            w2 = sine_ratio(gain_sine(phi2), sth);
         end else begin
            w1 = (longint'(1) << 30) - t30;
            w2 = t30;
         end
         for (int i = 0; i < 4; i++) res.o[i] = clip16(round_shift(w1 * a[i] + w2 * b[i], 30));
      end
      return res;
   endfunction

   always @(posedge clock) begin
      quat_result_type exp_res, got;
      request_type req;
      if (csr_wr_en) threshold = csr_wr_data;
      if (!reset && start && !busy) begin
         req.blend = req_blend;
         req.a = req_a;
         req.b = req_b;
         expected_q.push_back(cur_typed ? cur_res : slerp_predict(req, threshold));
      end
      if (!reset && rsp_strobe) begin
         got.o = rsp_out;
         got.lin = rsp_used_linear;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d lin=%0b", $time,
                     got.o[0], got.o[1], got.o[2], got.o[3], got.lin);
            n_errors++;
         end else begin
            exp_res = expected_q.pop_front();
            n_checked++;
            if (got.lin) n_linear++;
            for (int i = 0; i < 4; i++)
               if (got.o[i] !== exp_res.o[i]) begin
                  $display("%0t: component %0d expected %0d actual %0d", $time, i,
                           exp_res.o[i], got.o[i]);
                  n_errors++;
               end
            if (got.lin !== exp_res.lin) begin
               $display("%0t: used_linear expected %0b actual %0b", $time, exp_res.lin,
                        got.lin);
               n_errors++;
            end
         end
      end
   end

   task automatic send_request(request_type q, logic typed, quat_result_type res);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_blend = q.blend;
      req_a = q.a;
      req_b = q.b;
      cur_typed = typed;
      cur_res = res;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain();
      start = 1'b0;
      cur_typed = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_threshold(logic [15:0] value);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      @(negedge clock);
   endtask

   task automatic add_row(logic [15:0] blend, int ax, int ay, int az, int aw,
                          int bx, int by, int bz, int bw, logic typed,
                          int ox = 0, int oy = 0, int oz = 0, int ow = 0, logic lin = 0);
      stim_row_type row;
      row.req.blend = blend;
      row.req.a = '{comp_type'(ax), comp_type'(ay), comp_type'(az), comp_type'(aw)};
      row.req.b = '{comp_type'(bx), comp_type'(by), comp_type'(bz), comp_type'(bw)};
      row.typed = typed;
      row.res.o = '{comp_type'(ox), comp_type'(oy), comp_type'(oz), comp_type'(ow)};
      row.res.lin = lin;
      rows.push_back(row);
   endtask

   function automatic request_type random_request();
      request_type q;
      real v[4];
      real norm;
      int kind;
      kind = $urandom_range(99);
      q.blend = ($urandom_range(9) == 0) ? 16'($urandom_range(65535)) :
                16'($urandom_range(32768));
      if (kind < 15) begin
         for (int i = 0; i < 4; i++) begin
            q.a[i] = comp_type'($urandom_range(65535));
            q.b[i] = comp_type'($urandom_range(65535));
         end
         return q;
      end
      norm = 0.0;
      for (int i = 0; i < 4; i++) begin
         v[i] = real'(int'($urandom_range(65534)) - 32767);
         norm += v[i] * v[i];
      end
      if (norm < 1.0) begin
         v[3] = 1.0;
         norm = 1.0;
      end
      norm = $sqrt(norm);
      for (int i = 0; i < 4; i++) q.a[i] = clip16($rtoi(v[i] / norm * 32767.0));
      for (int i = 0; i < 4; i++) begin
         if (kind < 55) begin
            v[i] = real'(int'($urandom_range(65534)) - 32767);
         end else begin
            v[i] = real'(q.a[i]) + real'(int'($urandom_range(4000)) - 2000)
                   * real'($urandom_range(3) + 1) / 4.0;
            if (kind >= 80) v[i] = -v[i];
         end
      end
      norm = 0.0;
      for (int i = 0; i < 4; i++) norm += v[i] * v[i];
      if (norm < 1.0) begin
         v[0] = 1.0;
         norm = 1.0;
      end
      norm = $sqrt(norm);
      for (int i = 0; i < 4; i++) q.b[i] = clip16($rtoi(v[i] / norm * 32767.0));
      return q;
   endfunction

   initial begin
      logic [15:0] settings[5];
      quat_result_type none;
      none = '{o: '{default: '0}, lin: 1'b0};
      settings = '{16'd0, 16'd32768, 16'd16384, 16'($urandom_range(32768)),
                   qs_pkg::QS_THR_RESET};

      add_row(16'd16384, 0, 0, 0, 32767, 0, 0, 0, 32767, 1, 0, 0, 0, 32767, 1);
      add_row(16'd0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
      add_row(16'd0, 32767, 0, 0, 0, 0, 32767, 0, 0, 0);
      add_row(16'd32768, 32767, 0, 0, 0, 0, 32767, 0, 0, 0);
      add_row(16'd65535, 32767, 0, 0, 0, 0, 32767, 0, 0, 0);
      add_row(16'd16384, 32767, 0, 0, 0, 0, 32767, 0, 0, 0);
      add_row(16'd16384, 23170, 0, 0, 23170, 0, 0, 23170, 23170, 0);
      add_row(16'd8192, 0, 0, 0, 32767, 0, 0, 0, -32768, 0);
      add_row(16'd16384, 16384, 16384, 16384, 16384, -16384, -16384, -16384, -16384, 0);
      add_row(16'd16384, 32767, 0, 0, 0, -32768, 0, 0, 0, 0);
      add_row(16'd16384, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0);
      add_row(16'd20000, 32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 0);
      add_row(16'd12000, 32767, 0, 0, 0, 32760, 600, 0, 0, 0);
      add_row(16'd12000, 32767, 0, 0, 0, -32760, -600, 0, 0, 0);
      add_row(16'd30000, 10000, -20000, 5000, 23000, 12000, -19000, 3000, 23500, 0);
      add_row(16'd32767, 1, 2, 3, 4, 5, 6, 7, 8, 0);
      add_row(16'd1, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 0);
      add_row(16'd16384, 0, 0, 0, 32767, 0, 32767, 0, 0, 0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].res);
      drain();

      for (int p = 0; p < 5; p++) begin
         write_threshold(settings[p]);
         if (p == 0)
            send_request('{16'd16384, '{default: '0}, '{default: '0}}, 1,
                         '{o: '{default: '0}, lin: 1'b1});
         for (int k = 0; k < 110; k++) begin
            idle_pct = (p == 2 && k >= 10) ? 0 : 8;
            send_request(random_request(), 0, none);
         end
         drain();
      end

      repeat (120) @(negedge clock);
      $display("Checked %0d results (%0d linear, %0d spherical) over %0d threshold settings",
               n_checked, n_linear, n_checked - n_linear, 6);
      if (n_errors == 0 && expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
